// ----- rtl/crs_pkg.sv -----
// Shared types and constants for the Catmull-Rom spline evaluator.
package crs_pkg;

  localparam int MAX_POINTS = 64;
  localparam int AW         = $clog2(MAX_POINTS);
  localparam int FRAC_BITS  = 16;
  localparam int DW         = 32;
  localparam int QW         = 22;          // basis weight width, signed
  localparam int PW         = DW + QW;     // one product
  localparam int ACC_W      = PW + 2;      // sum of four products

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  localparam logic [1:0] CFG_LOOPED = 2'd0;
  localparam logic [1:0] CFG_COUNT  = 2'd1;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SEG = 2'd1,
    ST_FEW = 2'd2
  } status_t;

  typedef struct packed {
    logic                    mode;
    logic [5:0]              write_index;
    logic signed [DW-1:0]    point_x;
    logic signed [DW-1:0]    point_y;
    logic signed [DW-1:0]    point_z;
    logic signed [DW-1:0]    point_speed;
    logic [5:0]              segment;
    logic [FRAC_BITS-1:0]    fraction;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0] pos_x;
    logic signed [DW-1:0] pos_y;
    logic signed [DW-1:0] pos_z;
    logic signed [DW-1:0] grad_x;
    logic signed [DW-1:0] grad_y;
    logic signed [DW-1:0] grad_z;
    logic signed [DW-1:0] speed;
    status_t              status;
  } out_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
    logic signed [DW-1:0] v;
  } pt_t;

  typedef pt_t [3:0] quad_t;

  typedef logic [AW-1:0] addr_t;
  typedef addr_t [3:0] addr_quad_t;

  // query control handed from the front stage to the math pipeline
  typedef struct packed {
    logic                 valid;
    status_t              status;
    logic [FRAC_BITS-1:0] frac;
    logic [FRAC_BITS-1:0] tt;
  } qctl_t;

endpackage

// ----- rtl/crs_index.sv -----
// Neighbor index and status computation for one query.
module crs_index import crs_pkg::*; (
  input  logic       looped,
  input  logic [6:0] point_count,
  input  logic [5:0] segment,
  output addr_quad_t rd_addr,
  output status_t    status
);

  logic [6:0] cnt;
  logic [6:0] seg7;
  logic [6:0] s1;
  logic [6:0] s2;
  logic [6:0] s3;
  logic [6:0] s0m;
  logic [6:0] s2m;

  always_comb begin
    cnt  = (point_count > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : point_count;
    seg7 = {1'b0, segment};
    s1   = seg7 + 7'd1;
    s2   = seg7 + 7'd2;
    s3   = seg7 + 7'd3;
    s0m  = (seg7 == 7'd0) ? (cnt - 7'd1) : (seg7 - 7'd1);
    s2m  = s2 - cnt;

    if (cnt < 7'd4) begin
      status = ST_FEW;
    end else if (looped) begin
      status = (seg7 >= cnt) ? ST_SEG : ST_OK;
    end else begin
      status = (s3 >= cnt) ? ST_SEG : ST_OK;
    end

    if (looped) begin
      rd_addr[0] = s0m[AW-1:0];
      rd_addr[1] = seg7[AW-1:0];
      rd_addr[2] = (s1 == cnt) ? '0 : s1[AW-1:0];
      rd_addr[3] = (s2 >= cnt) ? s2m[AW-1:0] : s2[AW-1:0];
    end else begin
      rd_addr[0] = seg7[AW-1:0];
      rd_addr[1] = s1[AW-1:0];
      rd_addr[2] = s2[AW-1:0];
      rd_addr[3] = s3[AW-1:0];
    end
  end

endmodule

// ----- rtl/crs_table.sv -----
// One copy of the control point table: one write port, one registered read port.
module crs_table import crs_pkg::*; (
  input  logic  clk,
  input  logic  we,
  input  addr_t waddr,
  input  pt_t   wdata,
  input  logic  re,
  input  addr_t raddr,
  output pt_t   rdata
);

  pt_t mem [MAX_POINTS];
  pt_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/crs_math.sv -----
// Basis weights, products, rounding and saturation; holds the result register.
module crs_math import crs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  qctl_t ctl,
  input  quad_t pts,
  output logic  out_valid,
  output out_t  out_data
);

  function automatic logic signed [DW-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic hi_same;
    hi_same = (v[ACC_W-1:DW-1] == '0) || (v[ACC_W-1:DW-1] == '1);
    if (hi_same) begin
      sat32 = v[DW-1:0];
    end else if (v[ACC_W-1]) begin
      sat32 = {1'b1, {(DW-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(DW-1){1'b1}}};
    end
  endfunction

  // stage 2: ttt
  logic                  v2_r;
  status_t               st2_r;
  logic [FRAC_BITS-1:0]  f2_r, tt2_r, ttt2_r;
  quad_t                 p2_r;
  logic [2*FRAC_BITS-1:0] ttt_full;

  // stage 3: weights
  logic                  v3_r;
  status_t               st3_r;
  logic [FRAC_BITS-1:0]  f3_r;
  quad_t                 p3_r;
  logic signed [QW-1:0]  qp3_r [4];
  logic signed [QW-1:0]  qg3_r [4];
  logic signed [DW:0]    dv3_r;
  logic signed [QW-1:0]  qp_nxt [4];
  logic signed [QW-1:0]  qg_nxt [4];
  logic signed [QW-1:0]  fs, ts, us;

  // stage 4: products
  logic                  v4_r;
  status_t               st4_r;
  logic signed [DW-1:0]  v14_r;
  logic signed [PW-1:0]  pp4_r [3][4];
  logic signed [PW-1:0]  pg4_r [3][4];
  logic signed [PW-1:0]  ps4_r;
  logic signed [DW-1:0]  crd [3][4];

  // result
  logic                  out_valid_r;
  out_t                  out_r;
  out_t                  out_nxt;
  logic signed [ACC_W-1:0] accp [3];
  logic signed [ACC_W-1:0] accg [3];
  logic signed [ACC_W-1:0] accs;

  assign ttt_full = ctl.tt * ctl.frac;

  always_ff @(posedge clk) begin
    if (en) begin
      st2_r  <= ctl.status;
      f2_r   <= ctl.frac;
      tt2_r  <= ctl.tt;
      ttt2_r <= ttt_full[2*FRAC_BITS-1:FRAC_BITS];
      p2_r   <= pts;
    end
  end

  // weights are twice the standard basis, scaled by 2^FRAC_BITS
  always_comb begin
    fs = QW'($signed({1'b0, f2_r}));
    ts = QW'($signed({1'b0, tt2_r}));
    us = QW'($signed({1'b0, ttt2_r}));
    qp_nxt[0] = QW'(-us + 2 * ts - fs);
    qp_nxt[1] = QW'(3 * us - 5 * ts + 2 * (1 <<< FRAC_BITS));
    qp_nxt[2] = QW'(-3 * us + 4 * ts + fs);
    qp_nxt[3] = QW'(us - ts);
    qg_nxt[0] = QW'(-3 * ts + 4 * fs - (1 <<< FRAC_BITS));
    qg_nxt[1] = QW'(9 * ts - 10 * fs);
    qg_nxt[2] = QW'(-9 * ts + 8 * fs + (1 <<< FRAC_BITS));
    qg_nxt[3] = QW'(3 * ts - 2 * fs);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st3_r <= st2_r;
      f3_r  <= f2_r;
      p3_r  <= p2_r;
      dv3_r <= (DW+1)'(p2_r[2].v) - (DW+1)'(p2_r[1].v);
      for (int k = 0; k < 4; k++) begin
        qp3_r[k] <= qp_nxt[k];
        qg3_r[k] <= qg_nxt[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      crd[0][k] = p3_r[k].x;
      crd[1][k] = p3_r[k].y;
      crd[2][k] = p3_r[k].z;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st4_r <= st3_r;
      v14_r <= p3_r[1].v;
      ps4_r <= PW'(dv3_r * $signed({1'b0, f3_r}));
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 4; k++) begin
          pp4_r[a][k] <= PW'(crd[a][k] * qp3_r[k]);
          pg4_r[a][k] <= PW'(crd[a][k] * qg3_r[k]);
        end
      end
    end
  end

  // sum, add one half, floor by 2^(F+1), saturate
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      accp[a] = (ACC_W'(pp4_r[a][0]) + ACC_W'(pp4_r[a][1]) + ACC_W'(pp4_r[a][2])
                 + ACC_W'(pp4_r[a][3]) + (ACC_W'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
      accg[a] = (ACC_W'(pg4_r[a][0]) + ACC_W'(pg4_r[a][1]) + ACC_W'(pg4_r[a][2])
                 + ACC_W'(pg4_r[a][3]) + (ACC_W'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
    end
    accs = ((ACC_W'(ps4_r) + (ACC_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS)
           + ACC_W'(v14_r);

    out_nxt = '0;
    out_nxt.status = st4_r;
    if (st4_r == ST_OK) begin
      out_nxt.pos_x  = sat32(accp[0]);
      out_nxt.pos_y  = sat32(accp[1]);
      out_nxt.pos_z  = sat32(accp[2]);
      out_nxt.grad_x = sat32(accg[0]);
      out_nxt.grad_y = sat32(accg[1]);
      out_nxt.grad_z = sat32(accg[2]);
      out_nxt.speed  = sat32(accs);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v2_r        <= ctl.valid;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/catmull_rom_spline_eval_core.sv -----
// Top level of the uniform Catmull-Rom spline evaluator over a 3D point table.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------
//  in      | in  | in_valid / in_ready  | in_data   (in_t: write or query)
//  out     | out | out_valid/ out_ready | out_data  (out_t: pos, grad, speed)
//  cfg     | in  | cfg_valid/ cfg_ready | cfg_index, cfg_data (32 bits)
//
// Throughput one beat per cycle unless out_ready stalls the pipeline.
// Writes go into the four table copies and give no result.
// Four table copies let the four neighbor points be read at the same time.
// The whole pipeline moves only when the result register is empty or taken,
// so in_ready follows out_ready; cfg_ready is always high.
// Synchronous reset clears config registers and pipeline valids; the
// table is not cleared.
module catmull_rom_spline_eval_core import crs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic       looped_r;
  logic [6:0] count_r;

  logic       en;
  logic       acc;
  logic       wr;
  logic       qry;
  addr_quad_t rd_addr;
  status_t    status;
  pt_t        wpt;
  quad_t      pts;
  qctl_t      ctl_r;
  logic [2*FRAC_BITS-1:0] ff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      looped_r <= 1'b0;
      count_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LOOPED: looped_r <= cfg_data[0];
        CFG_COUNT:  count_r  <= cfg_data[6:0];
        default:    ;
      endcase
    end
  end

  // one global advance; the result register is the only place a beat waits
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign acc      = in_valid && en;
  assign wr       = acc && (in_data.mode == MODE_WRITE);
  assign qry      = acc && (in_data.mode == MODE_EVAL);

  crs_index u_index (
    .looped      (looped_r),
    .point_count (count_r),
    .segment     (in_data.segment),
    .rd_addr     (rd_addr),
    .status      (status)
  );

  assign wpt = '{x: in_data.point_x, y: in_data.point_y,
                 z: in_data.point_z, v: in_data.point_speed};

  // a write is in the table by the next edge, so a following query sees it
  for (genvar k = 0; k < 4; k++) begin : g_tab
    crs_table u_table (
      .clk   (clk),
      .we    (wr),
      .waddr (in_data.write_index[AW-1:0]),
      .wdata (wpt),
      .re    (en),
      .raddr (rd_addr[k]),
      .rdata (pts[k])
    );
  end

  assign ff = in_data.fraction * in_data.fraction;

  // only the valid bit is reset; the payload just follows the advance
  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r.status <= status;
      ctl_r.frac   <= in_data.fraction;
      ctl_r.tt     <= ff[2*FRAC_BITS-1:FRAC_BITS];
    end
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r.valid <= qry;
    end
  end

  crs_math u_math (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctl       (ctl_r),
    .pts       (pts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- tb/crs_checker.sv -----
// Scoreboard for the spline evaluator: tracks table and config, predicts and checks results.
`timescale 1ns / 100ps
module crs_checker import crs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_t        out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  longint tab_x[MAX_POINTS];
  longint tab_y[MAX_POINTS];
  longint tab_z[MAX_POINTS];
  longint tab_v[MAX_POINTS];
  logic       wrap_mode;
  logic [6:0] used_points;
  out_t       sample_queue[$];

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic out_t eval_curve(in_t q);
    out_t   r;
    int     cnt, s, k;
    int     ix[4];
    longint f, tt, ttt, v1, v2;
    longint qp[4], qg[4];
    longint ax, ay, az, gx, gy, gz;
    r = '0;
    r.status = ST_OK;
    cnt = (used_points > MAX_POINTS) ? MAX_POINTS : used_points;
    s = q.segment;
    if (cnt < 4) begin
      r.status = ST_FEW;
      return r;
    end
    if (wrap_mode) begin
      if (s >= cnt) begin
        r.status = ST_SEG;
        return r;
      end
      ix[1] = s;
      ix[0] = (s >= 1) ? s - 1 : cnt - 1;
      ix[2] = (s + 1) % cnt;
      ix[3] = (s + 2) % cnt;
    end else begin
      if (s + 3 >= cnt) begin
        r.status = ST_SEG;
        return r;
      end
      for (k = 0; k < 4; k++) ix[k] = s + k;
    end
    f   = q.fraction;
    tt  = (f * f) >>> FRAC_BITS;
    ttt = (tt * f) >>> FRAC_BITS;
    qp[0] = -ttt + 2 * tt - f;
    qp[1] = 3 * ttt - 5 * tt + 2 * 65536;
    qp[2] = -3 * ttt + 4 * tt + f;
    qp[3] = ttt - tt;
    qg[0] = -3 * tt + 4 * f - 65536;
    qg[1] = 9 * tt - 10 * f;
    qg[2] = -9 * tt + 8 * f + 65536;
    qg[3] = 3 * tt - 2 * f;
    ax = 0; ay = 0; az = 0; gx = 0; gy = 0; gz = 0;
    for (k = 0; k < 4; k++) begin
      ax += tab_x[ix[k]] * qp[k];
      ay += tab_y[ix[k]] * qp[k];
      az += tab_z[ix[k]] * qp[k];
      gx += tab_x[ix[k]] * qg[k];
      gy += tab_y[ix[k]] * qg[k];
      gz += tab_z[ix[k]] * qg[k];
    end
    // times one half, rounded half up
    r.pos_x  = clip32((ax + 65536) >>> (FRAC_BITS + 1));
    r.pos_y  = clip32((ay + 65536) >>> (FRAC_BITS + 1));
    r.pos_z  = clip32((az + 65536) >>> (FRAC_BITS + 1));
    r.grad_x = clip32((gx + 65536) >>> (FRAC_BITS + 1));
    r.grad_y = clip32((gy + 65536) >>> (FRAC_BITS + 1));
    r.grad_z = clip32((gz + 65536) >>> (FRAC_BITS + 1));
    v1 = tab_v[ix[1]];
    v2 = tab_v[ix[2]];
    r.speed = clip32(v1 + (((v2 - v1) * f + 32768) >>> FRAC_BITS));
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending = sample_queue.size();

  always @(posedge clk) begin
    out_t exp_r;
    if (!rst_n) begin
      wrap_mode   = 1'b0;
      used_points = '0;
      fail_count  = 0;
      sample_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (sample_queue.size() == 0) begin
          $display("%0t unexpected result beat: expected none actual %h", $time, out_data);
          fail_count++;
        end else begin
          exp_r = sample_queue.pop_front();
          check_field("pos_x", exp_r.pos_x, out_data.pos_x);
          check_field("pos_y", exp_r.pos_y, out_data.pos_y);
          check_field("pos_z", exp_r.pos_z, out_data.pos_z);
          check_field("grad_x", exp_r.grad_x, out_data.grad_x);
          check_field("grad_y", exp_r.grad_y, out_data.grad_y);
          check_field("grad_z", exp_r.grad_z, out_data.grad_z);
          check_field("speed", exp_r.speed, out_data.speed);
          check_field("status", 32'(exp_r.status), 32'(out_data.status));
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.mode == MODE_WRITE) begin
          tab_x[in_data.write_index] = in_data.point_x;
          tab_y[in_data.write_index] = in_data.point_y;
          tab_z[in_data.write_index] = in_data.point_z;
          tab_v[in_data.write_index] = in_data.point_speed;
        end else begin
          sample_queue.push_back(eval_curve(in_data));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_LOOPED) wrap_mode = cfg_data[0];
        else if (cfg_index == CFG_COUNT) used_points = cfg_data[6:0];
      end
    end
  end

endmodule

// ----- tb/tb_catmull_rom_spline_eval_core.sv -----
// Testbench top for the spline evaluator: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_catmull_rom_spline_eval_core;
  import crs_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_LOOPED;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;

  // flow-control knobs, percent of cycles idle
  int gap_pct = 0;
  int stall_pct = 0;
  // long receiver hold-off: main bumps the request, rx process counts it out
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // our view of the config, for steering segments into range
  logic       cur_loop = 1'b0;
  logic [6:0] cur_count = '0;

  always #6 clk = ~clk;

  catmull_rom_spline_eval_core i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  crs_checker i_chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  // receiver: random stalls plus the occasional long hold-off
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // watchdog
  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

  // one input beat; valid held until accepted
  task automatic send_beat(in_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // wait out every queued result plus the pipe depth, so config writes land idle
  task automatic drain();
    go_quiet();
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = $urandom;
  endtask

  task automatic set_mode(logic lp, logic [6:0] cnt);
    drain();
    write_reg(CFG_LOOPED, {$urandom_range(0, 1) ? 31'h7FFFFFFF : 31'h0, lp});
    write_reg(CFG_COUNT, {25'h0, cnt});
    cur_loop  = lp;
    cur_count = cnt;
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_frac();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t make_write(logic [5:0] slot);
    in_t it;
    it.mode        = MODE_WRITE;
    it.write_index = slot;
    it.point_x     = pick_coord();
    it.point_y     = pick_coord();
    it.point_z     = pick_coord();
    it.point_speed = pick_coord();
    it.segment     = 6'($urandom);
    it.fraction    = 16'($urandom);
    return it;
  endfunction

  function automatic in_t make_query(logic [5:0] seg, logic [15:0] frac);
    in_t it;
    it             = make_write(6'($urandom));  // junk point fields, ignored
    it.mode        = MODE_EVAL;
    it.segment     = seg;
    it.fraction    = frac;
    return it;
  endfunction

  // segment mostly inside the curve, sometimes anywhere
  function automatic logic [5:0] pick_seg();
    int cnt;
    cnt = (cur_count > MAX_POINTS) ? MAX_POINTS : cur_count;
    if (cnt < 4 || $urandom_range(0, 99) < 15) return 6'($urandom);
    if (cur_loop) return 6'($urandom_range(0, cnt - 1));
    return 6'($urandom_range(0, cnt - 4));
  endfunction

  initial begin
    logic       lp;
    logic [6:0] cnt;
    int         b, n;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // fill every slot first so no query ever reads an unwritten entry
    for (n = 0; n < MAX_POINTS; n++) send_beat(make_write(6'(n)));

    // directed: empty table setting, then edges of open and looped curves
    set_mode(1'b0, 7'd0);
    send_beat(make_query(6'd0, 16'h0000));            // too few points
    set_mode(1'b0, 7'd3);
    send_beat(make_query(6'd0, 16'h4000));            // still too few
    set_mode(1'b0, 7'd64);
    send_beat(make_query(6'd0, 16'h0000));            // fraction zero gives p1
    send_beat(make_query(6'd0, 16'hFFFF));
    send_beat(make_query(6'd60, 16'h8000));           // last open segment
    send_beat(make_query(6'd61, 16'h1234));           // out of range
    send_beat(make_query(6'd63, 16'hFFFF));
    send_beat(make_write(6'd0));
    send_beat(make_query(6'd0, 16'hFFFF));            // read right after write
    set_mode(1'b1, 7'd64);
    send_beat(make_query(6'd0, 16'h8000));            // p0 wraps to the top
    send_beat(make_query(6'd62, 16'hFFFF));
    send_beat(make_query(6'd63, 16'h0001));           // p2, p3 wrap to the bottom
    set_mode(1'b1, 7'd4);
    send_beat(make_query(6'd3, 16'h7FFF));
    send_beat(make_query(6'd4, 16'h7FFF));            // looped, out of range
    set_mode(1'b0, 7'd127);                           // clamps to table size
    send_beat(make_query(6'd60, 16'hC000));
    send_beat(make_query(6'd61, 16'hC000));

    // random: phases cycle the idle mix and the config
    for (b = 0; b < 14; b++) begin
      case (b % 7)
        0: begin lp = 1'b0; cnt = 7'd64; end
        1: begin lp = 1'b1; cnt = 7'd64; end
        2: begin lp = 1'b0; cnt = 7'd4;  end
        3: begin lp = 1'b1; cnt = 7'd4;  end
        4: begin lp = 1'($urandom); cnt = 7'($urandom_range(0, 3)); end
        5: begin lp = 1'($urandom); cnt = 7'($urandom_range(65, 127)); end
        default: begin lp = 1'($urandom); cnt = 7'($urandom_range(5, 63)); end
      endcase
      set_mode(lp, cnt);
      case (b % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 64; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 64; end
        default: begin gap_pct = 16; stall_pct = 16; end
      endcase
      // back-pressure fills the pipe and must stall the input side
      if (b == 2 || b == 9) hold_req++;
      for (n = 0; n < 95; n++) begin
        if ($urandom_range(0, 99) < 25) send_beat(make_write(6'($urandom)));
        else send_beat(make_query(pick_seg(), pick_frac()));
      end
    end

    go_quiet();
    gap_pct = 0;
    stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/crs_pkg.sv
rtl/crs_index.sv
rtl/crs_table.sv
rtl/crs_math.sv
rtl/catmull_rom_spline_eval_core.sv
tb/crs_checker.sv
tb/tb_catmull_rom_spline_eval_core.sv
